### hdl/bqsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsg_pkg
// Shared types, constants and saturation helpers for the quad4 Jacobian and
// shape-function derivative pipeline.
// ----------------------------------------------------------------------------
package bqsg_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int NODES               = 4;
  localparam int LANES               = 8;   // dN1/dx, dN1/dy, ... dN4/dy
  localparam int QBITS               = 32;  // quotient bits resolved by the divider
  localparam int IN_TDATA_W          = 288;
  localparam int OUT_TDATA_W         = 304;

  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

  // natural-point factors (1-r), (1+r), (1-s), (1+s) in Q4.14
  typedef struct packed {
    logic signed [17:0] rm;
    logic signed [17:0] rp;
    logic signed [17:0] sm;
    logic signed [17:0] sp;
  } nc_t;

  typedef struct packed {
    logic signed [31:0] j11;
    logic signed [31:0] j12;
    logic signed [31:0] j21;
    logic signed [31:0] j22;
    nc_t                nc;
  } jac_t;

  // determinant info carried alongside the divider lanes
  typedef struct packed {
    logic [63:0] dmag;      // rounded |det|
    logic        det_neg;
    logic        singular;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] m);
    logic signed [31:0] r;
    if (neg) begin
      r = (m > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - m);
    end else begin
      r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic neg, input logic [63:0] m);
    logic signed [47:0] r;
    if (neg) begin
      r = (m > 64'h0000_8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(64'd0 - m);
    end else begin
      r = (m > 64'h0000_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : 48'(m);
    end
    return r;
  endfunction

endpackage

### hdl/bqsg_jac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsg_jac
// Four-stage Jacobian front end: edge vectors, products with the natural
// factors, sums, then round to Q16.16 and saturate.
// ----------------------------------------------------------------------------
module bqsg_jac
  import bqsg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] x_i [NODES],
  input  logic signed [31:0] y_i [NODES],
  input  logic signed [15:0] r_i,
  input  logic signed [15:0] s_i,
  output logic               valid_o,
  output jac_t               jac_o
);

  logic [3:0]         v_q;
  logic signed [32:0] dif_d [LANES];
  logic signed [32:0] dif_q [LANES];
  logic signed [50:0] prd_d [LANES];
  logic signed [50:0] prd_q [LANES];
  logic signed [51:0] sum_d [4];
  logic signed [51:0] sum_q [4];
  logic signed [31:0] j_d   [4];
  nc_t                nc_d, nc1_q, nc2_q, nc3_q;
  jac_t               jac_q;

  // stage 1: edge differences, natural factors
  always_comb begin
    nc_d.rm  = ONE_Q14 - 18'(r_i);
    nc_d.rp  = ONE_Q14 + 18'(r_i);
    nc_d.sm  = ONE_Q14 - 18'(s_i);
    nc_d.sp  = ONE_Q14 + 18'(s_i);
    dif_d[0] = 33'(x_i[1]) - 33'(x_i[0]);
    dif_d[1] = 33'(x_i[2]) - 33'(x_i[3]);
    dif_d[2] = 33'(y_i[1]) - 33'(y_i[0]);
    dif_d[3] = 33'(y_i[2]) - 33'(y_i[3]);
    dif_d[4] = 33'(x_i[3]) - 33'(x_i[0]);
    dif_d[5] = 33'(x_i[2]) - 33'(x_i[1]);
    dif_d[6] = 33'(y_i[3]) - 33'(y_i[0]);
    dif_d[7] = 33'(y_i[2]) - 33'(y_i[1]);
  end

  // stage 2: products, even lanes take the minus factor
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (i < 4) begin
        prd_d[i] = 51'(dif_q[i]) * ((i % 2 == 0) ? 51'(nc1_q.sm) : 51'(nc1_q.sp));
      end else begin
        prd_d[i] = 51'(dif_q[i]) * ((i % 2 == 0) ? 51'(nc1_q.rm) : 51'(nc1_q.rp));
      end
    end
  end

  // stage 3: pair sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_d[i] = 52'(prd_q[2*i]) + 52'(prd_q[2*i+1]);
    end
  end

  // stage 4: round half away from zero by 16 bits, saturate
  always_comb begin
    logic [51:0] m;
    logic [51:0] rnd;
    m   = '0;
    rnd = '0;
    for (int i = 0; i < 4; i++) begin
      m      = sum_q[i][51] ? 52'(-sum_q[i]) : 52'(sum_q[i]);
      rnd    = (m + 52'h0_0000_0000_8000) >> 16;
      j_d[i] = sat32(sum_q[i][51], 64'(rnd));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif_q     <= dif_d;
      nc1_q     <= nc_d;
      prd_q     <= prd_d;
      nc2_q     <= nc1_q;
      sum_q     <= sum_d;
      nc3_q     <= nc2_q;
      jac_q.j11 <= j_d[0];
      jac_q.j12 <= j_d[1];
      jac_q.j21 <= j_d[2];
      jac_q.j22 <= j_d[3];
      jac_q.nc  <= nc3_q;
    end
  end

  assign valid_o = v_q[3];
  assign jac_o   = jac_q;

endmodule

### hdl/bqsg_adj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsg_adj
// Three stages: determinant and adjugate-row products, differences, then
// magnitudes and signs scaled for the divider.
// ----------------------------------------------------------------------------
module bqsg_adj
  import bqsg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  jac_t                                   jac_i,
  output logic                                   valid_o,
  output logic [51+2*COORD_FRAC_BITS-16-1:0]     num_o [LANES],
  output logic [LANES-1:0]                       neg_o,
  output logic [63:0]                            den_o,
  output logic                                   det_neg_o,
  output logic                                   det_zero_o
);

  localparam int K  = 2 * COORD_FRAC_BITS - 16;
  localparam int WA = 51 + K;

  logic [2:0]         v_q;
  logic signed [63:0] pa_q, pb_q;
  // j22*sm, j22*sp, j12*rm, j12*rp, j11*rm, j11*rp, j21*sm, j21*sp
  logic signed [49:0] p_d [LANES];
  logic signed [49:0] p_q [LANES];
  logic signed [63:0] det_q;
  logic signed [50:0] n_d [LANES];
  logic signed [50:0] n_q [LANES];
  logic [WA-1:0]      a_d [LANES];
  logic [WA-1:0]      a_q [LANES];
  logic [LANES-1:0]   neg_d, neg_q;
  logic [63:0]        den_q;
  logic               dneg_q, dzero_q;

  always_comb begin
    p_d[0] = 50'(jac_i.j22) * 50'(jac_i.nc.sm);
    p_d[1] = 50'(jac_i.j22) * 50'(jac_i.nc.sp);
    p_d[2] = 50'(jac_i.j12) * 50'(jac_i.nc.rm);
    p_d[3] = 50'(jac_i.j12) * 50'(jac_i.nc.rp);
    p_d[4] = 50'(jac_i.j11) * 50'(jac_i.nc.rm);
    p_d[5] = 50'(jac_i.j11) * 50'(jac_i.nc.rp);
    p_d[6] = 50'(jac_i.j21) * 50'(jac_i.nc.sm);
    p_d[7] = 50'(jac_i.j21) * 50'(jac_i.nc.sp);
  end

  // lanes ordered dN1/dx, dN1/dy, dN2/dx, ...
  always_comb begin
    n_d[0] = -51'(p_q[0]) + 51'(p_q[2]);
    n_d[1] = -51'(p_q[4]) + 51'(p_q[6]);
    n_d[2] =  51'(p_q[0]) + 51'(p_q[3]);
    n_d[3] = -51'(p_q[5]) - 51'(p_q[6]);
    n_d[4] =  51'(p_q[1]) - 51'(p_q[3]);
    n_d[5] =  51'(p_q[5]) - 51'(p_q[7]);
    n_d[6] = -51'(p_q[1]) - 51'(p_q[2]);
    n_d[7] =  51'(p_q[4]) + 51'(p_q[7]);
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a_d[i]   = WA'(n_q[i][50] ? 51'(-n_q[i]) : 51'(n_q[i])) << K;
      neg_d[i] = n_q[i][50] ^ det_q[63];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= 64'(jac_i.j11) * 64'(jac_i.j22);
      pb_q    <= 64'(jac_i.j12) * 64'(jac_i.j21);
      p_q     <= p_d;
      det_q   <= pa_q - pb_q;
      n_q     <= n_d;
      a_q     <= a_d;
      neg_q   <= neg_d;
      den_q   <= det_q[63] ? 64'(-det_q) : 64'(det_q);
      dneg_q  <= det_q[63];
      dzero_q <= (det_q == '0);
    end
  end

  assign valid_o    = v_q[2];
  assign num_o      = a_q;
  assign neg_o      = neg_q;
  assign den_o      = den_q;
  assign det_neg_o  = dneg_q;
  assign det_zero_o = dzero_q;

endmodule

### hdl/bqsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsg_div
// Eight-lane pipelined restoring divider sharing one divisor: overflow check,
// one quotient bit per stage, then round, sign and saturate.
// ----------------------------------------------------------------------------
module bqsg_div
  import bqsg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [51+2*COORD_FRAC_BITS-16-1:0] num_i [LANES],
  input  logic [LANES-1:0]                   neg_i,
  input  logic [63:0]                        den_i,
  input  logic                               det_neg_i,
  input  logic                               det_zero_i,
  output logic                               valid_o,
  output logic signed [31:0]                 dn_o [LANES],
  output logic signed [47:0]                 det_o,
  output logic                               singular_o
);

  localparam int K  = 2 * COORD_FRAC_BITS - 16;
  localparam int WA = 51 + K;
  localparam int WR = ((WA > QBITS + 64) ? WA : QBITS + 64) + 1;
  localparam int ST = QBITS + 1;

  logic [ST:0]        v_q;
  logic [WR-1:0]      rem_d [ST][LANES];
  logic [WR-1:0]      rem_q [ST][LANES];
  logic [QBITS-1:0]   quo_d [ST][LANES];
  logic [QBITS-1:0]   quo_q [ST][LANES];
  logic [LANES-1:0]   big_d, big_q [ST];
  logic [LANES-1:0]   neg_q [ST];
  logic [63:0]        den_q [ST];
  side_t              side_d, side_q [ST];
  logic signed [31:0] dn_d [LANES];
  logic signed [31:0] dn_q [LANES];
  logic signed [47:0] det_q;
  logic               sing_q;

  // stage 0: overflow check (quotient of 2^32 or more saturates anyway)
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      big_d[l] = WR'(num_i[l]) >= (WR'(den_i) << QBITS);
    end
    side_d.dmag     = 64'((65'(den_i) + (65'd1 << (COORD_FRAC_BITS - 1))) >> COORD_FRAC_BITS);
    side_d.det_neg  = det_neg_i;
    side_d.singular = det_zero_i;
  end

  // one quotient bit per stage, MSB first
  always_comb begin
    logic [WR-1:0] sh;
    logic          ge;
    sh = '0;
    ge = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      rem_d[0][l] = WR'(num_i[l]);
      quo_d[0][l] = '0;
    end
    for (int s = 1; s < ST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        sh          = WR'(den_q[s-1]) << (QBITS - s);
        ge          = rem_q[s-1][l] >= sh;
        rem_d[s][l] = ge ? rem_q[s-1][l] - sh : rem_q[s-1][l];
        quo_d[s][l] = {quo_q[s-1][l][QBITS-2:0], ge};
      end
    end
  end

  // final: round half away from zero, apply sign, saturate; zero when singular
  always_comb begin
    logic        up;
    logic [63:0] m;
    up = 1'b0;
    m  = '0;
    for (int l = 0; l < LANES; l++) begin
      up = {1'b0, rem_q[ST-1][l][63:0], 1'b0} >= {2'b00, den_q[ST-1]};
      m  = big_q[ST-1][l] ? (64'd1 << QBITS) : (64'(quo_q[ST-1][l]) + 64'(up));
      dn_d[l] = side_q[ST-1].singular ? '0 : sat32(neg_q[ST-1][l], m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ST-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      big_q[0]  <= big_d;
      neg_q[0]  <= neg_i;
      den_q[0]  <= den_i;
      side_q[0] <= side_d;
      for (int s = 1; s < ST; s++) begin
        rem_q[s]  <= rem_d[s];
        quo_q[s]  <= quo_d[s];
        big_q[s]  <= big_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
      dn_q   <= dn_d;
      det_q  <= side_q[ST-1].singular ? '0 :
                sat48(side_q[ST-1].det_neg, side_q[ST-1].dmag);
      sing_q <= side_q[ST-1].singular;
    end
  end

  assign valid_o    = v_q[ST];
  assign dn_o       = dn_q;
  assign det_o      = det_q;
  assign singular_o = sing_q;

endmodule

### hdl/bilinear_quad_strain_gradient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_quad_strain_gradient
// Pipeline: 4 Jacobian stages, 3 determinant/adjugate stages and 34 divider
//   stages incl. output register, from input transfer to result.
// Throughput: one item per cycle unless stalled; set by the pipelined divider.
// A stall freezes the whole pipeline; nothing is dropped or repeated.
// Reset (async, active low) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module bilinear_quad_strain_gradient
  import bqsg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // node1_x, node1_y, node2_x, node2_y, node3_x, node3_y, node4_x, node4_y,
  // r_coord, s_coord (from bit 0 up)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // dn1_dx, dn1_dy, dn2_dx, dn2_dy, dn3_dx, dn3_dy, dn4_dx, dn4_dy,
  // jacobian_det (from bit 0 up)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // singular
  output logic [0:0]             m_axis_tuser
);

  localparam int WA = 51 + 2 * COORD_FRAC_BITS - 16;

  logic               en;
  logic signed [31:0] x [NODES];
  logic signed [31:0] y [NODES];
  logic signed [15:0] r_coord, s_coord;

  logic               jac_valid;
  jac_t               jac;

  logic               adj_valid;
  logic [WA-1:0]      num [LANES];
  logic [LANES-1:0]   neg;
  logic [63:0]        den;
  logic               det_neg, det_zero;

  logic               out_valid;
  logic signed [31:0] dn [LANES];
  logic signed [47:0] det;
  logic               singular;

  // Global advance: the pipeline moves unless a result is held at the output.
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack the input transfer
  always_comb begin
    for (int n = 0; n < NODES; n++) begin
      x[n] = s_axis_tdata[64*n +: 32];
      y[n] = s_axis_tdata[64*n+32 +: 32];
    end
    r_coord = s_axis_tdata[256 +: 16];
    s_coord = s_axis_tdata[272 +: 16];
  end

  // Jacobian entries in Q16.16
  bqsg_jac u_jac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (x),
    .y_i     (y),
    .r_i     (r_coord),
    .s_i     (s_coord),
    .valid_o (jac_valid),
    .jac_o   (jac)
  );

  // determinant and adjugate numerators
  bqsg_adj #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_adj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (jac_valid),
    .jac_i      (jac),
    .valid_o    (adj_valid),
    .num_o      (num),
    .neg_o      (neg),
    .den_o      (den),
    .det_neg_o  (det_neg),
    .det_zero_o (det_zero)
  );

  // eight divisions by the shared determinant; last stage is the output register
  bqsg_div #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (adj_valid),
    .num_i      (num),
    .neg_i      (neg),
    .den_i      (den),
    .det_neg_i  (det_neg),
    .det_zero_i (det_zero),
    .valid_o    (out_valid),
    .dn_o       (dn),
    .det_o      (det),
    .singular_o (singular)
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      m_axis_tdata[32*l +: 32] = dn[l];
    end
    m_axis_tdata[256 +: 48] = det;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = singular;

endmodule

### hdl/bqsg_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsg_chk
// Port-level checks for the quad4 derivative pipeline, bound to the top.
// ----------------------------------------------------------------------------
module bqsg_chk
  import bqsg_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // input side is open exactly when the output is free to move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // singular results carry zero derivatives and zero determinant
  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("singular result with nonzero data");

endmodule

bind bilinear_quad_strain_gradient bqsg_chk u_bqsg_chk (.*);
